### rtl/core/psad_pkg.sv
// package for the ps-adpcm block decoder: constants, result type,
// predictor coefficients and the per-nibble decode and rounding functions
// no dependencies
package psad_pkg;

	localparam int COUNT_BITS_DEF = 20;
	localparam int INDEX_W        = 20;
	localparam int LOOP_MIN_SPAN  = 28;

	localparam logic [3:0] POS_SHIFT  = 4'd0;
	localparam logic [3:0] POS_FLAGS  = 4'd1;
	localparam logic [3:0] POS_LAST   = 4'd15;
	localparam logic [3:0] SHIFT_UNIT = 4'd12;
	localparam logic [3:0] FILTER_MAX = 4'd4;

	localparam int FLAG_END    = 0;
	localparam int FLAG_REPEAT = 1;
	localparam int FLAG_LOOP   = 2;

	localparam logic [2:0] FILT_NONE = 3'd0;
	localparam logic [2:0] FILT_ONE  = 3'd1;
	localparam logic [2:0] FILT_TWO  = 3'd2;
	localparam logic [2:0] FILT_THR  = 3'd3;
	localparam logic [2:0] FILT_FOUR = 3'd4;

	localparam logic signed [31:0] HIST_MAX = 32'sh7fffffff;
	localparam logic signed [31:0] HIST_MIN = -32'sh7fffffff - 32'sd1;
	localparam logic signed [31:0] CLAMP_HI = 32'sd33553408;
	localparam logic signed [31:0] CLAMP_LO = -32'sd33554432;

	typedef struct packed {
		logic signed [15:0]   pcm_sample;
		logic [INDEX_W-1:0]   sample_index;
		logic                 pair_last;
		logic                 waveform_end;
		logic                 loop_flag;
		logic [INDEX_W-1:0]   loop_point;
	} result_t;

	function automatic logic signed [7:0] coef_a(input logic [2:0] filt);
		logic signed [7:0] c;
		case (filt)
			FILT_ONE:  c = 8'sd60;
			FILT_TWO:  c = 8'sd115;
			FILT_THR:  c = 8'sd98;
			FILT_FOUR: c = 8'sd122;
			default:   c = 8'sd0;
		endcase
		return c;
	endfunction

	function automatic logic signed [7:0] coef_b(input logic [2:0] filt);
		logic signed [7:0] c;
		case (filt)
			FILT_TWO:  c = -8'sd52;
			FILT_THR:  c = -8'sd55;
			FILT_FOUR: c = -8'sd60;
			default:   c = 8'sd0;
		endcase
		return c;
	endfunction

	// new q.10 history value from one nibble
	function automatic logic signed [31:0] decode_step(
		input logic signed [31:0] recent,
		input logic signed [31:0] older,
		input logic [3:0]         nib,
		input logic [3:0]         shift,
		input logic [2:0]         filt
	);
		logic signed [3:0]  nib_s;
		logic signed [7:0]  ca;
		logic signed [7:0]  cb;
		logic signed [35:0] base;
		logic signed [40:0] acc;
		logic signed [41:0] sum;
		logic signed [31:0] res;
		nib_s = nib;
		ca = coef_a(filt);
		cb = coef_b(filt);
		if (shift <= SHIFT_UNIT) begin
			base = 36'(nib_s) <<< (5'd22 - 5'(shift));
		end else begin
			base = 36'(nib_s >>> (shift - SHIFT_UNIT)) <<< 10;
		end
		acc = 41'(recent) * 41'(ca) + 41'(older) * 41'(cb);
		sum = 42'(base) + 42'(acc >>> 6);
		if (sum > 42'(HIST_MAX)) begin
			res = HIST_MAX;
		end else if (sum < 42'(HIST_MIN)) begin
			res = HIST_MIN;
		end else begin
			res = sum[31:0];
		end
		return res;
	endfunction

	// clamp to 16 bits in q.10 and round half away from zero
	function automatic logic signed [15:0] round_sample(input logic signed [31:0] h);
		logic signed [31:0] c;
		logic signed [31:0] r;
		c = h;
		if (c > CLAMP_HI) begin
			c = CLAMP_HI;
		end
		if (c < CLAMP_LO) begin
			c = CLAMP_LO;
		end
		if (!c[31]) begin
			r = c + 32'sd512;
		end else begin
			r = c + 32'sd511;
		end
		return r[25:10];
	endfunction

endpackage

### rtl/core/ps_adpcm_block_decoder.sv
// ps-adpcm block decoder top level: input register, two chained predictor
// steps and a two-entry result register
// depends on psad_pkg
//
// channel  direction  handshake            payload
// in       sink       in_valid / in_stall  data_byte, waveform_start, input_last
// out      source     out_valid / out_stall pcm_sample, sample_index, pair_last,
//                                          waveform_end, loop_flag, loop_point
//
// header bytes give no samples; a data byte yields two samples that leave through
// the single output port, and the next data byte loads as the second sample leaves
// the first sample passes the input register, then the result register
// reset clears history, counters, input register and result count, no clearing pass
// out_stall holds the result pair; in_stall rises only while the input register
// holds a byte whose samples cannot yet be loaded
module ps_adpcm_block_decoder #(
	parameter int COUNT_BITS = psad_pkg::COUNT_BITS_DEF
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_stall,
	input  logic [7:0]         data_byte,
	input  logic               waveform_start,
	input  logic               input_last,
	output logic               out_valid,
	input  logic               out_stall,
	output logic signed [15:0] pcm_sample,
	output logic [19:0]        sample_index,
	output logic               pair_last,
	output logic               waveform_end,
	output logic               loop_flag,
	output logic [19:0]        loop_point
);

	logic              valid_s1;
	logic [7:0]        data_s1;
	logic              start_s1;
	logic              last_s1;

	logic signed [31:0]    hist_recent_q;
	logic signed [31:0]    hist_older_q;
	logic [3:0]            byte_pos_q;
	logic [3:0]            blk_shift_q;
	logic [2:0]            blk_filter_q;
	logic [2:0]            blk_flags_q;
	logic                  loop_seen_q;
	logic [COUNT_BITS-1:0] loop_start_q;
	logic [COUNT_BITS-1:0] emitted_q;
	logic                  finished_q;

	logic [1:0]        out_cnt_q;
	psad_pkg::result_t res0_q;
	psad_pkg::result_t res1_q;
	psad_pkg::result_t res_out;

	logic signed [31:0]    rec_e;
	logic signed [31:0]    old_e;
	logic [3:0]            pos_e;
	logic [3:0]            shift_e;
	logic [2:0]            filt_e;
	logic [2:0]            flags_e;
	logic                  seen_e;
	logic [COUNT_BITS-1:0] lstart_e;
	logic [COUNT_BITS-1:0] emit_e;
	logic                  fin_e;

	logic                  no_result;
	logic                  fire;
	logic                  in_xfer;
	logic                  out_xfer;
	logic signed [31:0]    h1;
	logic signed [31:0]    h2;
	logic [COUNT_BITS-1:0] idx1;
	logic [COUNT_BITS-1:0] emit_after;
	logic [COUNT_BITS-1:0] span;
	logic                  end_hit;
	logic                  loops;
	logic [COUNT_BITS+19:0] idx0_ext;
	logic [COUNT_BITS+19:0] idx1_ext;
	logic [COUNT_BITS+19:0] lstart_ext;
	logic [2:0]            new_filter;
	logic                  take_loop;

	// state as seen by the byte in the input register
	always_comb begin
		if (start_s1) begin
			rec_e    = '0;
			old_e    = '0;
			pos_e    = psad_pkg::POS_SHIFT;
			shift_e  = '0;
			filt_e   = psad_pkg::FILT_NONE;
			flags_e  = '0;
			seen_e   = 1'b0;
			lstart_e = '0;
			emit_e   = '0;
			fin_e    = 1'b0;
		end else begin
			rec_e    = hist_recent_q;
			old_e    = hist_older_q;
			pos_e    = byte_pos_q;
			shift_e  = blk_shift_q;
			filt_e   = blk_filter_q;
			flags_e  = blk_flags_q;
			seen_e   = loop_seen_q;
			lstart_e = loop_start_q;
			emit_e   = emitted_q;
			fin_e    = finished_q;
		end
	end

	assign no_result = fin_e || pos_e == psad_pkg::POS_SHIFT || pos_e == psad_pkg::POS_FLAGS;
	assign out_valid = out_cnt_q != 2'd0;
	assign out_xfer  = out_valid && !out_stall;
	assign fire      = valid_s1 && (no_result || out_cnt_q == 2'd0 ||
	                               (out_cnt_q == 2'd1 && out_xfer));
	assign in_stall  = valid_s1 && !fire;
	assign in_xfer   = in_valid && !in_stall;

	assign h1 = psad_pkg::decode_step(rec_e, old_e, data_s1[3:0], shift_e, filt_e);
	assign h2 = psad_pkg::decode_step(h1, rec_e, data_s1[7:4], shift_e, filt_e);

	assign idx1       = emit_e + COUNT_BITS'(1);
	assign emit_after = emit_e + COUNT_BITS'(2);
	assign span       = emit_after - lstart_e;
	assign end_hit    = pos_e == psad_pkg::POS_LAST &&
	                    (flags_e[psad_pkg::FLAG_END] || last_s1);
	assign loops      = flags_e[psad_pkg::FLAG_END] && flags_e[psad_pkg::FLAG_REPEAT] &&
	                    seen_e && span > COUNT_BITS'(psad_pkg::LOOP_MIN_SPAN);
	assign idx0_ext   = {20'd0, emit_e};
	assign idx1_ext   = {20'd0, idx1};
	assign lstart_ext = {20'd0, lstart_e};
	assign new_filter = (data_s1[7:4] > 4'(psad_pkg::FILTER_MAX)) ?
	                    psad_pkg::FILT_NONE : data_s1[6:4];
	assign take_loop  = data_s1[psad_pkg::FLAG_LOOP] && !seen_e;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			start_s1 <= 1'b0;
			last_s1  <= 1'b0;
			data_s1  <= '0;
		end else if (in_xfer) begin
			valid_s1 <= 1'b1;
			start_s1 <= waveform_start;
			last_s1  <= input_last;
			data_s1  <= data_byte;
		end else if (fire) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hist_recent_q <= '0;
			hist_older_q  <= '0;
			byte_pos_q    <= '0;
			blk_shift_q   <= '0;
			blk_filter_q  <= '0;
			blk_flags_q   <= '0;
			loop_seen_q   <= 1'b0;
			loop_start_q  <= '0;
			emitted_q     <= '0;
			finished_q    <= 1'b0;
		end else if (fire) begin
			hist_recent_q <= rec_e;
			hist_older_q  <= old_e;
			byte_pos_q    <= pos_e;
			blk_shift_q   <= shift_e;
			blk_filter_q  <= filt_e;
			blk_flags_q   <= flags_e;
			loop_seen_q   <= seen_e;
			loop_start_q  <= lstart_e;
			emitted_q     <= emit_e;
			finished_q    <= fin_e;
			if (!fin_e) begin
				byte_pos_q <= pos_e + 4'd1;
				if (pos_e == psad_pkg::POS_SHIFT) begin
					blk_shift_q  <= data_s1[3:0];
					blk_filter_q <= new_filter;
				end else if (pos_e == psad_pkg::POS_FLAGS) begin
					blk_flags_q <= data_s1[2:0];
					if (take_loop) begin
						loop_start_q <= emit_e;
						loop_seen_q  <= 1'b1;
					end
				end else begin
					hist_recent_q <= h2;
					hist_older_q  <= h1;
					emitted_q     <= emit_after;
					finished_q    <= end_hit;
				end
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_cnt_q <= 2'd0;
		end else if (fire && !no_result) begin
			out_cnt_q <= 2'd2;
		end else if (out_xfer) begin
			out_cnt_q <= out_cnt_q - 2'd1;
		end
	end

	// result pair payload
	always_ff @(posedge clk) begin
		if (fire && !no_result) begin
			res0_q.pcm_sample   <= psad_pkg::round_sample(h1);
			res0_q.sample_index <= idx0_ext[19:0];
			res0_q.pair_last    <= 1'b0;
			res0_q.waveform_end <= 1'b0;
			res0_q.loop_flag    <= 1'b0;
			res0_q.loop_point   <= '0;
			res1_q.pcm_sample   <= psad_pkg::round_sample(h2);
			res1_q.sample_index <= idx1_ext[19:0];
			res1_q.pair_last    <= 1'b1;
			res1_q.waveform_end <= end_hit;
			res1_q.loop_flag    <= end_hit && loops;
			res1_q.loop_point   <= (end_hit && loops) ? lstart_ext[19:0] : 20'd0;
		end
	end

	assign res_out      = (out_cnt_q == 2'd1) ? res1_q : res0_q;
	assign pcm_sample   = res_out.pcm_sample;
	assign sample_index = res_out.sample_index;
	assign pair_last    = res_out.pair_last;
	assign waveform_end = res_out.waveform_end;
	assign loop_flag    = res_out.loop_flag;
	assign loop_point   = res_out.loop_point;

endmodule

### rtl/core/psad_checker.sv
// port-level checks for the ps-adpcm block decoder, attached by bind
// depends on ps_adpcm_block_decoder
module psad_checker (
	input logic               clk,
	input logic               arst_n,
	input logic               out_valid,
	input logic               out_stall,
	input logic signed [15:0] pcm_sample,
	input logic               pair_last,
	input logic               waveform_end,
	input logic               loop_flag,
	input logic [19:0]        loop_point
);

	// stalled result holds
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(pcm_sample) && $stable(pair_last))
		else $error("stalled result changed");

	// second sample of a pair is ready right after the first transfer
	a_pair_follows: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_stall && !pair_last |=> out_valid && pair_last)
		else $error("second sample of pair missing");

	// waveform ends only on the second sample of a byte
	a_end_on_pair: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && waveform_end |-> pair_last)
		else $error("waveform end on first sample");

	// loop info only at waveform end
	a_loop_at_end: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !waveform_end |-> !loop_flag && loop_point == 20'd0)
		else $error("loop info outside waveform end");

endmodule

bind ps_adpcm_block_decoder psad_checker u_psad_checker (.*);

### dv/tb_ps_adpcm_block_decoder.sv
// self-checking testbench for the ps-adpcm block decoder: a queue-fed byte driver,
// a result monitor and a bit-exact decode predictor with randomized stalls
// depends on psad_pkg and ps_adpcm_block_decoder
module tb_ps_adpcm_block_decoder;

	localparam int CW             = psad_pkg::COUNT_BITS_DEF;
	localparam int ITEM_COUNT     = 1450;
	localparam int IDLE_PCT       = 24;
	localparam int HOLD_AT        = 400;
	localparam int HOLD_CYCLES    = 250;
	localparam int CALM_FROM      = 700;
	localparam int CALM_TO        = 1000;
	localparam int WATCHDOG_LIMIT = 2000;
	localparam int DRAIN_CYCLES   = 8;

	localparam longint HIST_TOP = 64'sh7fff_ffff;
	localparam longint HIST_BOT = -HIST_TOP - 1;
	localparam longint CLIP_TOP = 64'sd32767 * 1024;
	localparam longint CLIP_BOT = -64'sd32768 * 1024;

	typedef struct packed {
		logic [7:0] data;
		logic       wave_start;
		logic       last_byte;
	} byte_item_t;

	logic               clk;
	logic               arst_n         = 1'b0;
	logic               in_valid       = 1'b0;
	logic               in_stall;
	logic [7:0]         data_byte      = 8'd0;
	logic               waveform_start = 1'b0;
	logic               input_last     = 1'b0;
	logic               out_valid;
	logic               out_stall      = 1'b0;
	logic signed [15:0] pcm_sample;
	logic [19:0]        sample_index;
	logic               pair_last;
	logic               waveform_end;
	logic               loop_flag;
	logic [19:0]        loop_point;

	byte_item_t        pending_bytes[$];
	psad_pkg::result_t expected_samples[$];
	byte_item_t        drive_item;
	byte_item_t        taken_item;
	psad_pkg::result_t seen;
	psad_pkg::result_t want;

	logic in_taken    = 1'b0;
	int   sent_count  = 0;
	int   fail_count  = 0;
	int   quiet_count = 0;
	int   hold_left   = 0;
	logic hold_done   = 1'b0;
	logic calm;

	// decoder state mirrored from the block
	int            hist_recent  = 0;
	int            hist_older   = 0;
	logic [3:0]    byte_pos     = 4'd0;
	logic [3:0]    blk_shift    = 4'd0;
	logic [2:0]    blk_filter   = psad_pkg::FILT_NONE;
	logic [2:0]    blk_flags    = 3'd0;
	logic          loop_seen    = 1'b0;
	logic          wave_done    = 1'b0;
	logic [CW-1:0] loop_start   = '0;
	logic [CW-1:0] sample_count = '0;

	assign calm = sent_count >= CALM_FROM && sent_count < CALM_TO;

	ps_adpcm_block_decoder u_dut (
		.clk            (clk),
		.arst_n         (arst_n),
		.in_valid       (in_valid),
		.in_stall       (in_stall),
		.data_byte      (data_byte),
		.waveform_start (waveform_start),
		.input_last     (input_last),
		.out_valid      (out_valid),
		.out_stall      (out_stall),
		.pcm_sample     (pcm_sample),
		.sample_index   (sample_index),
		.pair_last      (pair_last),
		.waveform_end   (waveform_end),
		.loop_flag      (loop_flag),
		.loop_point     (loop_point)
	);

	always begin
		clk = 1'b1;
		#6;
		clk = 1'b0;
		#6;
	end

	task automatic add_byte(input logic [7:0] d, input logic s, input logic l);
		byte_item_t it;
		it.data       = d;
		it.wave_start = s;
		it.last_byte  = l;
		pending_bytes.insert(pending_bytes.size(), it);
	endtask

	// predicts the samples one accepted byte produces
	task automatic decode_byte(input byte_item_t it);
		psad_pkg::result_t r;
		logic [3:0]        pos;
		logic [3:0]        code;
		logic [CW-1:0]     span;
		longint            nib;
		longint            base;
		longint            pred;
		longint            total;
		longint            clip;
		longint            rnd;
		longint            ca;
		longint            cb;
		if (it.wave_start) begin
			hist_recent  = 0;
			hist_older   = 0;
			byte_pos     = 4'd0;
			blk_shift    = 4'd0;
			blk_filter   = psad_pkg::FILT_NONE;
			blk_flags    = 3'd0;
			loop_seen    = 1'b0;
			wave_done    = 1'b0;
			loop_start   = '0;
			sample_count = '0;
		end
		if (wave_done) begin
			return;
		end
		pos = byte_pos;
		byte_pos = byte_pos + 4'd1;
		if (pos == psad_pkg::POS_SHIFT) begin
			blk_shift  = it.data[3:0];
			blk_filter = (it.data[7:4] > psad_pkg::FILTER_MAX) ?
			             psad_pkg::FILT_NONE : it.data[6:4];
			return;
		end
		if (pos == psad_pkg::POS_FLAGS) begin
			blk_flags = it.data[2:0];
			if (blk_flags[psad_pkg::FLAG_LOOP] && !loop_seen) begin
				loop_start = sample_count;
				loop_seen  = 1'b1;
			end
			return;
		end
		for (int k = 0; k < 2; k++) begin
			code = (k == 0) ? it.data[3:0] : it.data[7:4];
			nib = code;
			if (nib > 7) begin
				nib = nib - 16;
			end
			if (blk_shift <= psad_pkg::SHIFT_UNIT) begin
				base = nib * (longint'(1) <<< (22 - int'(blk_shift)));
			end else begin
				base = (nib >>> (int'(blk_shift) - 12)) * 1024;
			end
			case (blk_filter)
				psad_pkg::FILT_ONE: begin
					ca = 60;
					cb = 0;
				end
				psad_pkg::FILT_TWO: begin
					ca = 115;
					cb = -52;
				end
				psad_pkg::FILT_THR: begin
					ca = 98;
					cb = -55;
				end
				psad_pkg::FILT_FOUR: begin
					ca = 122;
					cb = -60;
				end
				default: begin
					ca = 0;
					cb = 0;
				end
			endcase
			pred = (longint'(hist_recent) * ca + longint'(hist_older) * cb) >>> 6;
			total = base + pred;
			if (total > HIST_TOP) begin
				total = HIST_TOP;
			end
			if (total < HIST_BOT) begin
				total = HIST_BOT;
			end
			hist_older  = hist_recent;
			hist_recent = int'(total);
			clip = total;
			if (clip > CLIP_TOP) begin
				clip = CLIP_TOP;
			end
			if (clip < CLIP_BOT) begin
				clip = CLIP_BOT;
			end
			// round half away from zero
			if (clip >= 0) begin
				rnd = (clip + 512) >>> 10;
			end else begin
				rnd = -((-clip + 512) >>> 10);
			end
			r.pcm_sample   = rnd[15:0];
			r.sample_index = sample_count[psad_pkg::INDEX_W-1:0];
			sample_count   = sample_count + 1'b1;
			r.pair_last    = (k == 1);
			r.waveform_end = 1'b0;
			r.loop_flag    = 1'b0;
			r.loop_point   = '0;
			if (k == 1 && pos == psad_pkg::POS_LAST &&
			    (blk_flags[psad_pkg::FLAG_END] || it.last_byte)) begin
				span = sample_count - loop_start;
				r.waveform_end = 1'b1;
				if (blk_flags[psad_pkg::FLAG_END] && blk_flags[psad_pkg::FLAG_REPEAT] &&
				    loop_seen && span > psad_pkg::LOOP_MIN_SPAN) begin
					r.loop_flag  = 1'b1;
					r.loop_point = loop_start[psad_pkg::INDEX_W-1:0];
				end
				wave_done = 1'b1;
			end
			expected_samples.insert(expected_samples.size(), r);
		end
	endtask

	// input transfers feed the predictor, output transfers are checked
	always @(posedge clk) begin
		if (arst_n) begin
			if (out_valid && !out_stall) begin
				seen.pcm_sample   = pcm_sample;
				seen.sample_index = sample_index;
				seen.pair_last    = pair_last;
				seen.waveform_end = waveform_end;
				seen.loop_flag    = loop_flag;
				seen.loop_point   = loop_point;
				if (expected_samples.size() == 0) begin
					$error("unexpected sample %0d at index %0d", seen.pcm_sample,
					       seen.sample_index);
					fail_count++;
				end else begin
					want = expected_samples.pop_front();
					if (seen.pcm_sample !== want.pcm_sample) begin
						$error("pcm_sample expected %0d got %0d", want.pcm_sample,
						       seen.pcm_sample);
						fail_count++;
					end
					if (seen.sample_index !== want.sample_index) begin
						$error("sample_index expected %0d got %0d", want.sample_index,
						       seen.sample_index);
						fail_count++;
					end
					if (seen.pair_last !== want.pair_last) begin
						$error("pair_last expected %0b got %0b", want.pair_last,
						       seen.pair_last);
						fail_count++;
					end
					if (seen.waveform_end !== want.waveform_end) begin
						$error("waveform_end expected %0b got %0b", want.waveform_end,
						       seen.waveform_end);
						fail_count++;
					end
					if (seen.loop_flag !== want.loop_flag) begin
						$error("loop_flag expected %0b got %0b", want.loop_flag,
						       seen.loop_flag);
						fail_count++;
					end
					if (seen.loop_point !== want.loop_point) begin
						$error("loop_point expected %0d got %0d", want.loop_point,
						       seen.loop_point);
						fail_count++;
					end
				end
			end
			if (in_valid && !in_stall) begin
				taken_item.data       = data_byte;
				taken_item.wave_start = waveform_start;
				taken_item.last_byte  = input_last;
				decode_byte(taken_item);
				sent_count++;
			end
			in_taken <= in_valid && !in_stall;
			if ((in_valid && !in_stall) || (out_valid && !out_stall)) begin
				quiet_count = 0;
			end else begin
				quiet_count++;
			end
			if (quiet_count >= WATCHDOG_LIMIT) begin
				$display("tb_ps_adpcm_block_decoder: FAIL");
				$finish;
			end
		end
	end

	// byte driver
	always @(negedge clk) begin
		if (arst_n && (!in_valid || in_taken)) begin
			if (pending_bytes.size() != 0 && (calm || $urandom_range(0, 99) >= IDLE_PCT)) begin
				drive_item = pending_bytes.pop_front();
				in_valid       <= 1'b1;
				data_byte      <= drive_item.data;
				waveform_start <= drive_item.wave_start;
				input_last     <= drive_item.last_byte;
			end else begin
				in_valid <= 1'b0;
			end
		end
	end

	// sample receiver with one long hold-off
	always @(negedge clk) begin
		if (!hold_done && sent_count >= HOLD_AT) begin
			hold_left = HOLD_CYCLES;
			hold_done = 1'b1;
		end
		if (hold_left != 0) begin
			out_stall <= 1'b1;
			hold_left--;
		end else begin
			out_stall <= !calm && $urandom_range(0, 99) < IDLE_PCT;
		end
	end

	initial begin
		logic [7:0] warmup [14];
		logic [7:0] hdr;
		logic [7:0] fl;
		logic [7:0] d;
		logic [3:0] filt;
		logic       lst;
		logic       is_final;
		int         nblk;
		int         style;
		int         loop_blk;
		int         ending;
		int         n;
		warmup = '{8'h77, 8'h77, 8'h77, 8'h77, 8'h77, 8'h88, 8'h88,
		           8'h88, 8'h88, 8'h88, 8'h00, 8'hff, 8'h0f, 8'hf0};

		// saturating filter 4 block, loop start on the ending block (span of 28,
		// no loop), input_last mid-block, then bytes after the end
		add_byte(8'h40, 1'b1, 1'b0);
		add_byte(8'h07, 1'b0, 1'b0);
		for (int i = 0; i < 14; i++) begin
			add_byte(warmup[i], 1'b0, i == 3);
		end
		add_byte(8'h55, 1'b0, 1'b0);
		add_byte(8'haa, 1'b0, 1'b1);

		while (pending_bytes.size() < ITEM_COUNT) begin
			nblk     = $urandom_range(1, 5);
			style    = $urandom_range(0, 15);
			loop_blk = $urandom_range(0, nblk);
			ending   = $urandom_range(0, 2);
			for (int b = 0; b < nblk; b++) begin
				is_final = (b == nblk - 1);
				if ($urandom_range(0, 9) < 8) begin
					filt = 4'($urandom_range(0, 4));
				end else begin
					filt = 4'($urandom_range(5, 15));
				end
				hdr = {filt, 4'($urandom_range(0, 15))};
				fl = 8'($urandom_range(0, 255));
				fl[psad_pkg::FLAG_END]  = 1'b0;
				fl[psad_pkg::FLAG_LOOP] = 1'b0;
				if (b >= loop_blk) begin
					fl[psad_pkg::FLAG_LOOP] = (b == loop_blk) || ($urandom_range(0, 3) == 0);
				end
				if (is_final && style != 0) begin
					fl[psad_pkg::FLAG_END] = (ending != 1);
				end else if (style == 1 && b == 0) begin
					// premature end, the rest of the waveform is dropped
					fl[psad_pkg::FLAG_END] = 1'b1;
				end
				add_byte(hdr, b == 0, 1'b0);
				add_byte(fl, 1'b0, $urandom_range(0, 15) == 0);
				for (int i = 2; i < 16; i++) begin
					case ($urandom_range(0, 7))
						0:       d = 8'h77;
						1:       d = 8'h88;
						default: d = 8'($urandom_range(0, 255));
					endcase
					if (i == 15) begin
						lst = is_final && style != 0 && ending != 0;
					end else begin
						lst = ($urandom_range(0, 15) == 0);
					end
					add_byte(d, 1'b0, lst);
				end
			end
			if (style == 0) begin
				// unterminated waveform cut off mid-block by the next start
				n = $urandom_range(1, 9);
				for (int i = 0; i < n; i++) begin
					add_byte(8'($urandom_range(0, 255)), 1'b0, $urandom_range(0, 7) == 0);
				end
			end else if ($urandom_range(0, 3) == 0) begin
				n = $urandom_range(1, 3);
				for (int i = 0; i < n; i++) begin
					add_byte(8'($urandom_range(0, 255)), 1'b0, 1'($urandom_range(0, 1)));
				end
			end
		end

		repeat (12) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		while (pending_bytes.size() != 0 || in_valid) begin
			@(posedge clk);
		end
		while (expected_samples.size() != 0) begin
			@(posedge clk);
		end
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (expected_samples.size() != 0) begin
			$error("%0d expected samples never arrived", expected_samples.size());
			fail_count++;
		end
		if (fail_count == 0) begin
			$display("tb_ps_adpcm_block_decoder: PASS");
		end else begin
			$display("tb_ps_adpcm_block_decoder: FAIL");
		end
		$finish;
	end

endmodule
